[rtl/jts_pkg.sv]
// Shared types, constants and helper functions for the JIS to Shift_JIS stream core.
// Used by jts_conv, jts_emit and the top level; depends on nothing else.
package jts_pkg;

	// Charset modes
	localparam logic [1:0] MODE_COPY  = 2'd0;
	localparam logic [1:0] MODE_KANA  = 2'd1;
	localparam logic [1:0] MODE_X0208 = 2'd2;
	localparam logic [1:0] MODE_X0212 = 2'd3;

	// Escape sequence bytes
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_D      = 8'h44;

	// Register map
	localparam int unsigned ADDR_W         = 2;
	localparam logic [ADDR_W-1:0] ADDR_UNDEF = 2'd0;
	localparam logic [15:0] UNDEF_RESET    = 16'h81AC;

	localparam int unsigned MAX_BEATS = 4;

	// All output beats caused by one input byte
	typedef struct packed {
		logic [MAX_BEATS-1:0][7:0] bytes;
		logic [2:0]                cnt;   // 0..4 beats
		logic                      bare;  // single end marker, no data
		logic                      fin;   // last beat closes the stream
	} res_t;

	// Append one byte to a result bundle, dropping anything past four
	function automatic res_t push_byte(res_t r, logic [7:0] v);
		res_t o;
		o = r;
		if (r.cnt < 3'(MAX_BEATS)) begin
			o.bytes[r.cnt[1:0]] = v;
			o.cnt = r.cnt + 3'd1;
		end
		return o;
	endfunction

	// JIS X 0208 row/cell pair to Shift_JIS, first (high) byte
	function automatic logic [7:0] sjis_hi(logic [7:0] j0);
		logic [7:0] h;
		logic [7:0] add;
		h = j0 | 8'h80;
		if (j0[0]) add = (h < 8'hDF) ? 8'h31 : 8'h71;
		else       add = (h < 8'hDF) ? 8'h30 : 8'h70;
		return (h >> 1) + add;
	endfunction

	// Second (low) byte; wraps modulo 256
	function automatic logic [7:0] sjis_lo(logic [7:0] j0, logic [7:0] j1);
		logic [7:0] l;
		l = j1 | 8'h80;
		if (j0[0]) return l - ((l < 8'hE0) ? 8'h61 : 8'h60);
		else       return l - 8'h02;
	endfunction

endpackage

[rtl/jts_conv.sv]
// Decoder state and per-byte conversion: escape tracking, mode, pending lead byte.
// Produces the bundle of output beats for the accepted byte. Depends on jts_pkg.
module jts_conv (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     data_byte,
	input  logic           stream_last,
	input  logic [15:0]    undef_code,
	output jts_pkg::res_t  res
);
	import jts_pkg::*;

	logic [1:0] mode_q,    mode_d;
	logic [1:0] esc_cnt_q, esc_cnt_d;
	logic [7:0] esc1_q,    esc1_d;    // second escape byte; first is always ESC, third '('
	logic [7:0] lead_q,    lead_d;
	logic       lead_pend_q, lead_pend_d;

	// Next state and output beats for this byte
	always_comb begin
		res_t r;
		logic consumed;
		r = '0;
		consumed = 1'b0;
		mode_d = mode_q;
		esc_cnt_d = esc_cnt_q;
		esc1_d = esc1_q;
		lead_d = lead_q;
		lead_pend_d = lead_pend_q;

		// Held escape: extend, complete, or break and dump raw
		if (esc_cnt_q != 2'd0) begin
			if (esc_cnt_q == 2'd1 && (data_byte == CH_LPAREN || data_byte == CH_DOLLAR)) begin
				esc1_d = data_byte;
				esc_cnt_d = 2'd2;
				consumed = 1'b1;
			end else if (esc_cnt_q == 2'd2 && esc1_q == CH_LPAREN
					&& (data_byte == CH_B || data_byte == CH_I)) begin
				mode_d = (data_byte == CH_B) ? MODE_COPY : MODE_KANA;
				esc_cnt_d = 2'd0;
				consumed = 1'b1;
			end else if (esc_cnt_q == 2'd2 && esc1_q == CH_DOLLAR && data_byte == CH_B) begin
				mode_d = MODE_X0208;
				esc_cnt_d = 2'd0;
				consumed = 1'b1;
			end else if (esc_cnt_q == 2'd2 && esc1_q == CH_DOLLAR && data_byte == CH_LPAREN) begin
				esc_cnt_d = 2'd3;
				consumed = 1'b1;
			end else if (esc_cnt_q == 2'd3 && data_byte == CH_D) begin
				mode_d = MODE_X0212;
				esc_cnt_d = 2'd0;
				consumed = 1'b1;
			end else begin
				r = push_byte(r, CH_ESC);
				if (esc_cnt_q >= 2'd2) r = push_byte(r, esc1_q);
				if (esc_cnt_q == 2'd3) r = push_byte(r, CH_LPAREN);
				esc_cnt_d = 2'd0;
				mode_d = MODE_COPY;
			end
		end

		// Byte handled in the current mode
		if (!consumed) begin
			if (data_byte == CH_ESC) begin
				if (lead_pend_d && mode_d == MODE_X0208) begin
					r = push_byte(r, undef_code[15:8]);
					r = push_byte(r, undef_code[7:0]);
				end
				lead_pend_d = 1'b0;
				esc1_d = esc1_q;
				esc_cnt_d = 2'd1;
			end else if (mode_d == MODE_COPY) begin
				r = push_byte(r, data_byte);
			end else if (mode_d == MODE_KANA) begin
				r = push_byte(r, data_byte | 8'h80);
			end else if (!lead_pend_d) begin
				lead_d = data_byte;
				lead_pend_d = 1'b1;
			end else begin
				if (mode_d == MODE_X0208) begin
					r = push_byte(r, sjis_hi(lead_q));
					r = push_byte(r, sjis_lo(lead_q, data_byte));
				end else begin
					r = push_byte(r, undef_code[15:8]);
					r = push_byte(r, undef_code[7:0]);
				end
				lead_pend_d = 1'b0;
			end
		end

		// Stream end: flush partial escape and, in X0208 mode, a lone lead, then clear
		if (stream_last) begin
			if (esc_cnt_d != 2'd0) r = push_byte(r, CH_ESC);
			if (esc_cnt_d >= 2'd2) r = push_byte(r, esc1_d);
			if (esc_cnt_d == 2'd3) r = push_byte(r, CH_LPAREN);
			if (lead_pend_d && mode_d == MODE_X0208) begin
				r = push_byte(r, undef_code[15:8]);
				r = push_byte(r, undef_code[7:0]);
			end
			if (r.cnt == 3'd0) begin
				r.cnt = 3'd1;
				r.bare = 1'b1;
			end
			r.fin = 1'b1;
			mode_d = MODE_COPY;
			esc_cnt_d = 2'd0;
			lead_pend_d = 1'b0;
		end
		res = r;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COPY;
			esc_cnt_q <= 2'd0;
			lead_pend_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			esc_cnt_q <= esc_cnt_d;
			lead_pend_q <= lead_pend_d;
		end
	end

	// Held bytes, meaningful only under their count/pending flag
	always_ff @(posedge clk) begin
		if (accept) begin
			esc1_q <= esc1_d;
			lead_q <= lead_d;
		end
	end

endmodule

[rtl/jts_emit.sv]
// Two-entry queue of result bundles and the serializer that sends one byte per beat.
// Depends on jts_pkg for the bundle type.
module jts_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  jts_pkg::res_t  res,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           byte_valid,
	output logic           run_last,
	output logic           stream_end
);
	import jts_pkg::*;

	res_t       q_mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	res_t       head;
	logic       push, pop, beat, last_beat;

	assign head      = q_mem[rd_ptr_q];
	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign last_beat = ({1'b0, idx_q} == (head.cnt - 3'd1));
	assign beat      = out_valid && out_ready;
	assign pop       = beat && last_beat;
	// Bytes that cause no beat still update the decoder but are not queued
	assign push      = accept && (res.cnt != 3'd0);

	// Output beat fields from the head bundle
	assign out_byte   = head.bytes[idx_q];
	assign byte_valid = !head.bare;
	assign run_last   = last_beat;
	assign stream_end = head.fin && last_beat;

	// Bundle storage
	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= res;
	end

	// Pointers, occupancy, beat index within head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				idx_q <= 2'd0;
			end else if (beat) begin
				idx_q <= idx_q + 2'd1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/jis_to_shift_jis_stream_core.sv]
// Top level of the JIS (ISO-2022-JP) to Shift_JIS stream converter.
// Instantiates jts_conv and jts_emit; uses jts_pkg and holds the APB register.
//
// One input byte is taken per clock while in_ready is high; the decoder updates
// its mode, escape and lead-byte state in the same cycle and queues the zero to
// four output beats that byte causes. Beats leave a two-deep bundle queue one
// per clock while out_ready is high, so input runs at one byte per cycle while
// each byte yields at most one beat, and otherwise at the output rate. A byte
// producing no beat (escape bytes, a held lead byte) is taken without using the
// output. Bytes with stream_last close the stream with at least one beat; a
// bare end marker has byte_valid low. The replacement code register sits at
// byte address 0 and resets to 0x81AC.
module jis_to_shift_jis_stream_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       stream_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       byte_valid,
	output logic                       run_last,
	output logic                       stream_end,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jts_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import jts_pkg::*;

	logic [15:0] undef_code_q;
	logic        accept;
	res_t        res;

	assign accept = in_valid && in_ready;
	assign pready = 1'b1;

	// Replacement code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undef_code_q <= UNDEF_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_UNDEF) begin
			undef_code_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr == ADDR_UNDEF) ? {16'h0000, undef_code_q} : 32'h0000_0000;

	jts_conv u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.stream_last (stream_last),
		.undef_code  (undef_code_q),
		.res         (res)
	);

	jts_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.res        (res),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.stream_end (stream_end)
	);

endmodule

[rtl/jts_chk.sv]
// Port-level checker for the JIS to Shift_JIS stream core, bound to the top level.
// Watches only the handshake and output ports; no other dependencies.
module jts_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       run_last,
	input logic       stream_end
);

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
			&& $stable(run_last) && $stable(stream_end))
		else $error("output beat changed while stalled");

	// The closing beat of a stream is also the last beat of its byte
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> run_last)
		else $error("stream_end without run_last");

	// A bare marker only ever closes a stream
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> run_last && stream_end)
		else $error("bare marker not at stream end");

	// Input only backs up when results are waiting
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with nothing to send");

endmodule

bind jis_to_shift_jis_stream_core jts_chk u_jts_chk (.*);
